// ===== src/plo_pkg.sv =====
// Package for the positional ordered list: sizes, codes, word and control types.
`timescale 1ns / 1ps
package plo_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 5;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  localparam int OP_W     = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ_ALL  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_cmd_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
  } cell_ctl_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    has_value;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
    logic [COUNT_W-1:0]      count;
  } out_word_t;

endpackage

// ===== src/plo_cell.sv =====
// One list slot: holds an entry and moves it to or from its neighbors.
`timescale 1ns / 1ps
module plo_cell (
  input  logic                            clk,
  input  plo_pkg::cell_ctl_t              ctl,
  input  logic [plo_pkg::CNT_W-1:0]       my_idx,
  input  logic signed [plo_pkg::VAL_W-1:0] new_val,
  input  logic signed [plo_pkg::VAL_W-1:0] left_val,
  input  logic signed [plo_pkg::VAL_W-1:0] right_val,
  input  logic signed [plo_pkg::VAL_W-1:0] head_val,
  output logic signed [plo_pkg::VAL_W-1:0] val
);
  import plo_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.cmd)
      CELL_INSERT: begin
        if (my_idx == ctl.idx) begin
          val_nxt = new_val;
        end else if (my_idx > ctl.idx) begin
          val_nxt = left_val;
        end
      end
      CELL_DELETE: begin
        if (my_idx >= ctl.idx) begin
          val_nxt = right_val;
        end
      end
      CELL_ROTATE: begin
        // tail of the occupied ring wraps to the head entry
        if (my_idx == ctl.cnt - CNT_W'(1)) begin
          val_nxt = head_val;
        end else begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== src/positional_ordered_list_top.sv =====
// Top level of the positional ordered list: cell chain, control FSM and output register.
`timescale 1ns / 1ps
// Bounded ordered list of signed 32-bit entries, up to CAPACITY of them, kept in
// a chain of cells with the front entry in cell 0. Every insert or delete, at
// the front, the back or a 1-based position, gives one status word with the new
// count, and one that succeeds also shifts the chain; the next word can be taken
// as soon as the output register is free. A read-all rotates the occupied cells
// one step per cycle while the output register is free, emitting cell 0 each
// step: input is held off until the last step, after which the list is back in
// its original order (an empty list gives one status word instead). New words
// are taken only while no read-all is running and the output register is free or
// being drained. Operation code 7 is dropped without a result.
module positional_ordered_list_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  plo_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output plo_pkg::out_word_t out_word
);
  import plo_pkg::*;

  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  cell_ctl_t        ctl;
  logic signed [VAL_W-1:0] cell_val [CAPACITY];

  logic             out_free;
  logic             accept;
  logic [POS_W:0]   pos_x;    // position, one bit wider for the +1 compare
  logic [POS_W:0]   cnt_x;
  logic [CNT_W-1:0] pos_idx;  // zero-based slot from the 1-based position
  logic             full;
  logic             empty;

  // ---------------------------------------------------------------------------
  // Cell chain. Cell 0 has no left neighbor; the last cell refills from itself.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_val[i];
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_v = cell_val[i];
    end else begin : g_next
      assign right_v = cell_val[i+1];
    end
    plo_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .my_idx    (CNT_W'(i)),
      .new_val   (in_word.value),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .val       (cell_val[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == FSM_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign pos_x   = {1'b0, in_word.position};
  assign cnt_x   = (POS_W + 1)'(cnt_r);
  assign pos_idx = CNT_W'(in_word.position - POS_W'(1));
  assign full    = (cnt_r == CNT_W'(CAPACITY));
  assign empty   = (cnt_r == '0);

  // ---------------------------------------------------------------------------
  // Control: decode the word, drive the chain, build the result word.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    ctl.cmd       = CELL_HOLD;
    ctl.idx       = '0;
    ctl.cnt       = cnt_r;

    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          // edit result defaults; count is filled in below
          out_word_nxt.status      = ST_OK;
          out_word_nxt.has_value   = 1'b0;
          out_word_nxt.entry_value = '0;
          out_word_nxt.last        = 1'b1;
          out_valid_nxt            = 1'b1;
          unique case (op_t'(in_word.operation)) inside
            OP_INS_FIRST, OP_INS_LAST: begin
              if (full) begin
                out_word_nxt.status = ST_FULL;
              end else begin
                ctl.cmd = CELL_INSERT;
                ctl.idx = (op_t'(in_word.operation) == OP_INS_FIRST) ? '0 : cnt_r;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            OP_INS_AT: begin
              if (in_word.position == '0 || pos_x > cnt_x + (POS_W + 1)'(1)) begin
                out_word_nxt.status = ST_BADPOS;
              end else if (full) begin
                out_word_nxt.status = ST_FULL;
              end else begin
                ctl.cmd = CELL_INSERT;
                ctl.idx = pos_idx;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            OP_DEL_FIRST, OP_DEL_LAST: begin
              if (empty) begin
                out_word_nxt.status = ST_EMPTY;
              end else begin
                ctl.cmd = CELL_DELETE;
                ctl.idx = (op_t'(in_word.operation) == OP_DEL_FIRST) ? '0
                                                                     : cnt_r - CNT_W'(1);
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            OP_DEL_AT: begin
              if (in_word.position == '0 || pos_x > cnt_x) begin
                out_word_nxt.status = ST_BADPOS;
              end else begin
                ctl.cmd = CELL_DELETE;
                ctl.idx = pos_idx;
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            OP_READ_ALL: begin
              if (empty) begin
                out_word_nxt.status = ST_EMPTY;
              end else begin
                // entries go out from the read state, one per cycle while the output register is free
                out_valid_nxt = out_valid_r && !out_ready;
                rd_nxt        = '0;
                state_nxt     = FSM_READ;
              end
            end
            default: begin
              // unused code: no result
              out_valid_nxt = out_valid_r && !out_ready;
              out_word_nxt  = out_word_r;
            end
          endcase
          out_word_nxt.count = COUNT_W'(cnt_nxt);
        end
      end
      FSM_READ: begin
        if (out_free) begin
          ctl.cmd                  = CELL_ROTATE;
          out_valid_nxt            = 1'b1;
          out_word_nxt.status      = ST_OK;
          out_word_nxt.has_value   = 1'b1;
          out_word_nxt.entry_value = cell_val[0];
          out_word_nxt.last        = (rd_r == cnt_r - CNT_W'(1));
          out_word_nxt.count       = COUNT_W'(cnt_r);
          rd_nxt                   = rd_r + CNT_W'(1);
          if (rd_r == cnt_r - CNT_W'(1)) begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
